// ===== src/sgf_tok_pkg.sv =====
// shared types, character codes and sizes for the sgf stream tokenizer
package sgf_tok_pkg;

  // sizes
  localparam int POSITION_BITS_DEF = 16;
  localparam int TOKEN_BITS        = 16;
  localparam int QUEUE_DEPTH       = 4;

  // characters the lexer reacts to
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  // lexing mode
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_PROP   = 2'd1,
    MODE_VALUE  = 2'd2,
    MODE_ESC    = 2'd3
  } lex_mode_t;

  // token kinds
  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_SEMI  = 3'd2,
    KIND_PROP  = 3'd3,
    KIND_VALUE = 3'd4,
    KIND_ERROR = 3'd5
  } tok_kind_t;

  // one queued token
  typedef struct packed {
    tok_kind_t              kind;
    logic [TOKEN_BITS-1:0]  start;
    logic [TOKEN_BITS-1:0]  length;
    logic                   last;
  } token_t;

endpackage

// ===== src/sgf_tok_in_if.sv =====
// text byte channel: valid/ready with one byte and an end-of-text flag
interface sgf_tok_in_if import sgf_tok_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

// ===== src/sgf_tok_out_if.sv =====
// token channel: valid/ready with kind, start offset, length and last flag
interface sgf_tok_out_if import sgf_tok_pkg::*; ();
  logic                  valid;
  logic                  ready;
  tok_kind_t             token_kind;
  logic [TOKEN_BITS-1:0] token_start;
  logic [TOKEN_BITS-1:0] token_length;
  logic                  last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

// ===== src/sgf_stream_tokenizer.sv =====
// Streaming SGF lexer. One text byte is taken per request and lexed in the cycle it is
// accepted; the zero, one or two tokens it causes go into a four-entry token queue that
// drives the output channel from registers. A byte is accepted whenever at least two queue
// entries are free, so with the token side ready the block takes one byte every cycle; the
// sustained rate is bound by the output side, which drains one token per cycle, so a byte
// that closes a property and also emits its own token puts two tokens in the queue. Tokens
// carry a start offset and a length (saturating at 65535); positions count in POSITION_BITS
// and saturate. After a byte flagged end_of_input, all lexer state returns to reset and the
// next byte starts a new text at offset zero. No clearing time is needed after reset.
module sgf_stream_tokenizer import sgf_tok_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  sgf_tok_in_if.sink    text,
  sgf_tok_out_if.source tokens
);

  localparam int PW         = POSITION_BITS;
  localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS   = QPTR_BITS + 1;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
  localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = {TOKEN_BITS{1'b1}};

  // saturate a position-wide value to the token field width
  function automatic logic [TOKEN_BITS-1:0] sat_tok(input logic [PW-1:0] v);
    logic [TOKEN_BITS-1:0] r;
    if (v > PW'(TOKEN_MAX)) begin
      r = TOKEN_MAX;
    end else begin
      r = TOKEN_BITS'(v);
    end
    return r;
  endfunction

  function automatic token_t mk_tok(input tok_kind_t k, input logic [PW-1:0] s,
                                    input logic [PW-1:0] l);
    token_t t;
    t.kind   = k;
    t.start  = sat_tok(s);
    t.length = sat_tok(l);
    t.last   = 1'b0;
    return t;
  endfunction

  // lexer state
  lex_mode_t     lex_mode, lex_mode_next;
  logic [PW-1:0] byte_position, byte_position_next;
  logic [PW-1:0] open_token_start, open_token_start_next;

  // token queue
  token_t               queue [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]  count, count_next;

  logic in_take, out_take;

  // byte classification
  logic [7:0] c;
  logic       eoi, is_space, is_upper;
  logic       nb_tok_valid;
  tok_kind_t  nb_kind;

  assign c        = text.text_byte;
  assign eoi      = text.end_of_input;
  assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);

  // token for a byte seen in normal mode
  always_comb begin
    nb_tok_valid = 1'b1;
    nb_kind      = KIND_ERROR;
    if (is_space || is_upper || c == CH_LBRACK) begin
      nb_tok_valid = 1'b0;
    end else if (c == CH_LPAREN) begin
      nb_kind = KIND_OPEN;
    end else if (c == CH_RPAREN) begin
      nb_kind = KIND_CLOSE;
    end else if (c == CH_SEMI) begin
      nb_kind = KIND_SEMI;
    end
  end

  // per-byte lexing: up to three candidate tokens, at most two valid
  logic [PW-1:0] pos, next_pos;
  lex_mode_t     mode_after;
  logic [PW-1:0] ots_after;
  logic          run_normal;
  logic          c0v, c1v, c2v;
  token_t        c0, c1, c2;

  assign pos      = byte_position;
  assign next_pos = (pos != POS_MAX) ? pos + PW'(1) : pos;

  always_comb begin
    mode_after = lex_mode;
    ots_after  = open_token_start;
    run_normal = 1'b0;
    c0v = 1'b0;
    c1v = 1'b0;
    c2v = 1'b0;
    c0  = mk_tok(KIND_PROP, open_token_start, pos - open_token_start);
    c1  = mk_tok(nb_kind, pos, PW'(1));
    c2  = mk_tok(KIND_VALUE, open_token_start, pos - open_token_start);

    case (lex_mode)
      MODE_PROP: begin
        if (!is_upper) begin
          c0v        = 1'b1;
          mode_after = MODE_NORMAL;
          run_normal = 1'b1;
        end
      end
      MODE_VALUE: begin
        if (c == CH_RBRACK) begin
          c0v        = 1'b1;
          c0.kind    = KIND_VALUE;
          mode_after = MODE_NORMAL;
        end else if (c == CH_BSLASH && !eoi) begin
          mode_after = MODE_ESC;
        end
      end
      MODE_ESC: begin
        mode_after = MODE_VALUE;
      end
      default: begin
        mode_after = MODE_NORMAL;
        run_normal = 1'b1;
      end
    endcase

    // normal-mode handling, possibly after a property closed
    if (run_normal) begin
      c1v = nb_tok_valid;
      if (is_upper) begin
        mode_after = MODE_PROP;
        ots_after  = pos;
      end else if (c == CH_LBRACK) begin
        mode_after = MODE_VALUE;
        ots_after  = next_pos;
      end
    end

    // end of text flushes an open property or value
    if (eoi) begin
      if (mode_after == MODE_PROP) begin
        c2v = 1'b1;
        c2  = mk_tok(KIND_PROP, ots_after, next_pos - ots_after);
      end else if (mode_after == MODE_VALUE || mode_after == MODE_ESC) begin
        c2v = 1'b1;
        c2  = mk_tok(KIND_VALUE, ots_after, next_pos - ots_after);
      end
    end

    // state update
    if (eoi) begin
      lex_mode_next         = MODE_NORMAL;
      byte_position_next    = '0;
      open_token_start_next = '0;
    end else begin
      lex_mode_next         = mode_after;
      byte_position_next    = next_pos;
      open_token_start_next = ots_after;
    end
  end

  // pack the valid candidates into two write slots
  token_t     o0, o1;
  logic [1:0] push_n;

  always_comb begin
    push_n = 2'(c0v) + 2'(c1v) + 2'(c2v);
    o0 = c0v ? c0 : (c1v ? c1 : c2);
    o1 = c0v ? (c1v ? c1 : c2) : c2;
    o0.last = (push_n == 2'd1);
    o1.last = 1'b1;
  end

  // handshakes
  assign text.ready = (count <= CNT_BITS'(QUEUE_DEPTH - 2));
  assign in_take    = text.valid && text.ready;
  assign out_take   = tokens.valid && tokens.ready;

  always_comb begin
    count_next = count;
    if (in_take) begin
      count_next = count_next + CNT_BITS'(push_n);
    end
    if (out_take) begin
      count_next = count_next - CNT_BITS'(1);
    end
  end

  // lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= MODE_NORMAL;
      byte_position    <= '0;
      open_token_start <= '0;
    end else if (in_take) begin
      lex_mode         <= lex_mode_next;
      byte_position    <= byte_position_next;
      open_token_start <= open_token_start_next;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (in_take) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(push_n);
      end
      if (out_take) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
    end
  end

  // queue entries
  always_ff @(posedge clk) begin
    if (in_take && push_n != 2'd0) begin
      queue[wr_ptr] <= o0;
    end
    if (in_take && push_n == 2'd2) begin
      queue[wr_ptr + QPTR_BITS'(1)] <= o1;
    end
  end

  // output channel from the queue head
  assign tokens.valid        = (count != '0);
  assign tokens.token_kind   = queue[rd_ptr].kind;
  assign tokens.token_start  = queue[rd_ptr].start;
  assign tokens.token_length = queue[rd_ptr].length;
  assign tokens.last_of_run  = queue[rd_ptr].last;

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("token queue count above depth");

  // a request is only taken with room for two tokens
  a_room_on_take: assert property (@(posedge clk) disable iff (rst)
    in_take |-> (CNT_BITS'(QUEUE_DEPTH) - count) >= CNT_BITS'(2))
    else $error("request taken without room for two tokens");

  // end of text returns the lexer to its reset state
  a_eoi_resets: assert property (@(posedge clk) disable iff (rst)
    in_take && eoi |=> lex_mode == MODE_NORMAL && byte_position == '0
                       && open_token_start == '0)
    else $error("lexer state not cleared after end of text");

  // a two-token request marks only the second as last
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    in_take && push_n == 2'd2 |-> !o0.last && o1.last)
    else $error("last flag misplaced on two-token request");

endmodule
